// ===== rtl/core/mzr_pkg.sv =====
// Shared types and codes for the move-to-front zero-run symbol decoder.
package mzr_pkg;

  // Width of the pending run counter and of the repeat count in a result.
  localparam int RUN_BITS = 20;

  // Result kinds.
  localparam logic [1:0] KIND_RUN = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // Number of results one item produces (zero, one or two).
  localparam logic [1:0] NRES_NONE = 2'd0;
  localparam logic [1:0] NRES_ONE  = 2'd1;
  localparam logic [1:0] NRES_TWO  = 2'd2;

  // One result item.
  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          out_byte;
    logic [RUN_BITS-1:0] repeat_res;
    logic                is_last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic exec;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] nres;
  } dp_stat_t;

  // Push requests from the controller to the result queue.
  typedef struct packed {
    logic push0;
    logic push1;
  } q_push_t;

endpackage

// ===== rtl/core/mzr_ctrl.sv =====
// Controller state machine: sequences capture, list read and execute of one item.
module mzr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mzr_pkg::dp_stat_t stat,
  input  logic [1:0]        q_free,
  output mzr_pkg::dp_cmd_t  cmd,
  output mzr_pkg::q_push_t  push
);
  import mzr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    push       = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // Commit only when the result queue has room for every result of the item.
        if (q_free >= stat.nres) begin
          cmd.exec   = 1'b1;
          push.push0 = (stat.nres != NRES_NONE);
          push.push1 = (stat.nres == NRES_TWO);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mzr_dp.sv =====
// Datapath: move-to-front list cells, run counter and weight, result formation.
module mzr_dp #(
  parameter int LIST_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata,
  input  logic              func,
  input  logic [8:0]        symbol,
  input  logic [7:0]        load_index,
  input  logic [7:0]        load_value,
  input  mzr_pkg::dp_cmd_t  cmd,
  output mzr_pkg::dp_stat_t stat,
  output mzr_pkg::res_t     res0,
  output mzr_pkg::res_t     res1
);
  import mzr_pkg::*;

  localparam int IDXW = $clog2(LIST_SIZE);
  localparam logic [8:0] LIST_N = 9'(LIST_SIZE);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(LIST_SIZE - 1);
  localparam logic [RUN_BITS+2:0] RUN_MAX = {3'b000, {RUN_BITS{1'b1}}};
  localparam logic [RUN_BITS+1:0] WEIGHT_CAP = {2'b01, {RUN_BITS{1'b0}}};

  // Captured item and configuration.
  logic       func_r;
  logic [8:0] sym_r;
  logic [7:0] lidx_r;
  logic [7:0] lval_r;
  logic [8:0] in_use;

  // Decoder state.
  logic [7:0]          cells [LIST_SIZE];
  logic [RUN_BITS-1:0] pending;
  logic [RUN_BITS:0]   weight;
  logic [7:0]          mtf_val;

  // Combinational decode.
  logic [8:0]          n_eff;
  logic [8:0]          eob;
  logic [8:0]          sym_m1;
  logic [IDXW-1:0]     idx_sel;
  logic                is_run;
  logic                is_bad;
  logic                is_eob;
  logic                has_flush;
  logic [RUN_BITS:0]   w_eff;
  logic [RUN_BITS+1:0] add;
  logic [RUN_BITS+2:0] sum;
  logic                run_ovf;
  logic [RUN_BITS+1:0] w_dbl;
  logic [RUN_BITS:0]   weight_next;
  logic                do_load;
  logic                do_move;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= 9'd256;
    end else if (cfg_we) begin
      in_use <= cfg_wdata;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func;
      sym_r  <= symbol;
      lidx_r <= load_index;
      lval_r <= load_value;
    end
  end

  // Symbol classification against the clamped in-use count.
  always_comb begin
    if (in_use == 9'd0) begin
      n_eff = 9'd1;
    end else if (in_use > LIST_N) begin
      n_eff = LIST_N;
    end else begin
      n_eff = in_use;
    end
    eob       = n_eff + 9'd1;
    sym_m1    = sym_r - 9'd1;
    idx_sel   = (sym_m1 >= LIST_N) ? LAST_IDX : sym_m1[IDXW-1:0];
    is_run    = (sym_r <= 9'd1);
    is_bad    = !is_run && (sym_r > eob);
    is_eob    = !is_run && (sym_r == eob);
    has_flush = (pending != '0);
  end

  // Run arithmetic: weight of zero counts as one, RUNB adds twice the weight.
  always_comb begin
    w_eff       = (weight == '0) ? {{RUN_BITS{1'b0}}, 1'b1} : weight;
    add         = sym_r[0] ? {w_eff, 1'b0} : {1'b0, w_eff};
    sum         = {3'b000, pending} + {1'b0, add};
    run_ovf     = (sum > RUN_MAX);
    w_dbl       = {w_eff, 1'b0};
    weight_next = (w_dbl > WEIGHT_CAP) ? WEIGHT_CAP[RUN_BITS:0] : w_dbl[RUN_BITS:0];
  end

  // Result count and result formation.
  always_comb begin
    res0 = '{kind: KIND_ERR, out_byte: 8'd0, repeat_res: RUN_BITS'(0), is_last: 1'b1};
    res1 = '{kind: KIND_RUN, out_byte: mtf_val, repeat_res: RUN_BITS'(1), is_last: 1'b1};
    if (!func_r) begin
      stat.nres = NRES_NONE;
    end else if (is_run) begin
      stat.nres = run_ovf ? NRES_ONE : NRES_NONE;
    end else if (is_bad) begin
      stat.nres = NRES_ONE;
    end else begin
      stat.nres = has_flush ? NRES_TWO : NRES_ONE;
      if (is_eob) begin
        res1 = '{kind: KIND_END, out_byte: 8'd0, repeat_res: RUN_BITS'(0), is_last: 1'b1};
      end
      if (has_flush) begin
        res0 = '{kind: KIND_RUN, out_byte: cells[0], repeat_res: pending,
                 is_last: 1'b0};
      end else begin
        res0 = res1;
      end
    end
  end

  assign do_load = cmd.exec && !func_r;
  assign do_move = cmd.exec && func_r && !is_run && !is_bad && !is_eob;

  // Register the selected list entry in the list read step, ahead of the shift.
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      mtf_val <= cells[idx_sel];
    end
  end

  // Run state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      weight  <= '0;
    end else if (cmd.exec) begin
      if (func_r && is_run && !run_ovf) begin
        pending <= sum[RUN_BITS-1:0];
        weight  <= weight_next;
      end else begin
        pending <= '0;
        weight  <= '0;
      end
    end
  end

  // List cells: the front cell loads or receives the moved entry; the others
  // load, or shift back by one up to the moved position.
  always_ff @(posedge clk) begin
    if (rst) begin
      cells[0] <= 8'd0;
    end else if (do_load && lidx_r == 8'd0) begin
      cells[0] <= lval_r;
    end else if (do_move) begin
      cells[0] <= mtf_val;
    end
    for (int i = 1; i < LIST_SIZE; i++) begin
      if (rst) begin
        cells[i] <= 8'(i);
      end else if (do_load && lidx_r == 8'(i)) begin
        cells[i] <= lval_r;
      end else if (do_move && IDXW'(i) <= idx_sel) begin
        cells[i] <= cells[i-1];
      end
    end
  end

endmodule

// ===== rtl/core/mzr_outq.sv =====
// Two-entry result queue between the datapath and the output channel.
module mzr_outq (
  input  logic             clk,
  input  logic             rst,
  input  mzr_pkg::q_push_t push,
  input  mzr_pkg::res_t    d0,
  input  mzr_pkg::res_t    d1,
  output logic [1:0]       free,
  output logic             out_valid,
  input  logic             out_ready,
  output mzr_pkg::res_t    head
);
  import mzr_pkg::*;

  res_t       q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       pop;
  logic [1:0] npush;

  assign out_valid = (count != 2'd0);
  assign head      = q[rd_ptr];
  assign free      = 2'd2 - count;
  assign pop       = out_valid && out_ready;
  assign npush     = {1'b0, push.push0} + {1'b0, push.push1};

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      rd_ptr <= rd_ptr ^ pop;
      wr_ptr <= wr_ptr ^ npush[0];
      count  <= count + npush - {1'b0, pop};
    end
  end

  // Entry storage: the second result goes behind the first.
  always_ff @(posedge clk) begin
    if (push.push0) begin
      q[wr_ptr] <= d0;
    end
    if (push.push1) begin
      q[~wr_ptr] <= d1;
    end
  end

endmodule

// ===== rtl/core/mtf_zero_run_symbol_decoder.sv =====
// Top level of the move-to-front zero-run symbol decoder.
//
// Takes Huffman-decoded bzip2 symbols and load items on a valid/ready input channel and
// gives byte-run, end-of-block and error results on a valid/ready output channel. Each
// item goes through capture, list read and execute, and no new item is accepted until
// the item before it has executed; the move-to-front update itself is a parallel shift
// of the list cells. Results go into a two-entry queue, so a new item is accepted while
// earlier results still wait; execution of an item waits only when the queue lacks room
// for all of its results (at most two). The list resets to entry i holding value i, the
// run state to zero, and in_use_count to 256; in_use_count is written through cfg_we and
// cfg_wdata, by the user only while the decoder is idle; the block does not enforce this.
module mtf_zero_run_symbol_decoder #(
  parameter int LIST_SIZE = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [8:0]                   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [8:0]                   symbol,
  input  logic [7:0]                   load_index,
  input  logic [7:0]                   load_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [7:0]                   out_byte,
  output logic [mzr_pkg::RUN_BITS-1:0] repeat_res,
  output logic                         is_last
);
  import mzr_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  q_push_t    push;
  res_t       res0;
  res_t       res1;
  res_t       head;
  logic [1:0] q_free;

  mzr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .q_free   (q_free),
    .cmd      (cmd),
    .push     (push)
  );

  mzr_dp #(
    .LIST_SIZE (LIST_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .func       (func),
    .symbol     (symbol),
    .load_index (load_index),
    .load_value (load_value),
    .cmd        (cmd),
    .stat       (stat),
    .res0       (res0),
    .res1       (res1)
  );

  mzr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .d0        (res0),
    .d1        (res1),
    .free      (q_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Output fields come straight from the queue head.
  assign kind       = head.kind;
  assign out_byte   = head.out_byte;
  assign repeat_res = head.repeat_res;
  assign is_last    = head.is_last;

`ifndef SYNTHESIS
  // The queue never reports more free entries than it has.
  a_free_range: assert property (@(posedge clk) disable iff (rst) q_free <= 2'd2)
    else $error("result queue free count out of range");

  // Two results are pushed only into an empty queue.
  a_push_two_room: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> (push.push0 && q_free == 2'd2))
    else $error("second result pushed without room");

  // An accepted item keeps the input closed while it is worked on.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // Results are pushed only on the execute command.
  a_push_exec: assert property (@(posedge clk) disable iff (rst)
    push.push0 |-> cmd.exec)
    else $error("result pushed outside execute");
`endif

endmodule

// ===== sim/tb_mtf_zero_run_symbol_decoder.sv =====
// Self-checking testbench for the move-to-front zero-run symbol decoder.
module tb_mtf_zero_run_symbol_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import mzr_pkg::*;

  // Input item codes.
  localparam logic       FUNC_LOAD   = 1'b0;
  localparam logic       FUNC_DECODE = 1'b1;
  localparam logic [8:0] SYM_RUNA    = 9'd0;
  localparam logic [8:0] SYM_RUNB    = 9'd1;

  localparam logic [19:0] RUN_MAX       = 20'hFFFFF;
  localparam logic [21:0] WEIGHT_CAP    = 22'h100000;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          CYCLE_LIMIT   = 2000000;
  localparam int          PHASE_ITEMS   = 190;

  typedef struct {
    logic       func;
    logic [8:0] sym;
    logic [7:0] idx;
    logic [7:0] val;
  } sym_item_t;

  // Block ports.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [8:0]  symbol = '0;
  logic [7:0]  load_index = '0;
  logic [7:0]  load_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [19:0] repeat_res;
  logic        is_last;

  // Pending items, expected results and the decoder state as predicted.
  sym_item_t   stim_q[$];
  res_t        want_q[$];
  logic [7:0]  list_m[256];
  logic [19:0] run_len;
  logic [20:0] run_wt;
  logic [8:0]  in_use_m;

  // Idle control and bookkeeping.
  bit quiet_in  = 1'b0;
  bit quiet_out = 1'b0;
  int gap_left   = 0;
  int stall_left = 0;
  int cycle_cnt  = 0;
  int err_count  = 0;
  int items_in   = 0;
  int queued_items = 0;
  int phases_run = 0;
  int seen_run = 0;
  int seen_end = 0;
  int seen_err = 0;

  mtf_zero_run_symbol_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .symbol    (symbol),
    .load_index(load_index),
    .load_value(load_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .repeat_res(repeat_res),
    .is_last   (is_last)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  // Print one mismatch line, keeping the log short on a bad run.
  task automatic report_mismatch(input string msg);
    if (err_count < 40) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    err_count++;
  endtask

  function automatic void push_want(input logic [1:0] k, input logic [7:0] b,
                                    input logic [19:0] r, input logic l);
    res_t w;
    w.kind = k;
    w.out_byte = b;
    w.repeat_res = r;
    w.is_last = l;
    want_q.insert(want_q.size(), w);
  endfunction

  // Work out the results of one accepted item and update the predicted state.
  task automatic predict_decode(input logic f, input logic [8:0] s,
                                input logic [7:0] li, input logic [7:0] lv);
    logic [9:0]  n;
    logic [9:0]  eob;
    logic [21:0] w;
    logic [21:0] add;
    logic [21:0] sum;
    logic [7:0]  v;
    int          idx;
    n = {1'b0, in_use_m};
    if (n < 10'd1) begin
      n = 10'd1;
    end
    if (n > 10'd256) begin
      n = 10'd256;
    end
    eob = n + 10'd1;
    if (f == FUNC_LOAD) begin
      list_m[li] = lv;
      run_len = '0;
      run_wt = '0;
    end else if (s == SYM_RUNA || s == SYM_RUNB) begin
      // Zero-run digit: add the weight once or twice, then double it.
      w = (run_wt == '0) ? 22'd1 : {1'b0, run_wt};
      add = (s == SYM_RUNA) ? w : (w << 1);
      sum = {2'b00, run_len} + add;
      if (sum > {2'b00, RUN_MAX}) begin
        run_len = '0;
        run_wt = '0;
        push_want(KIND_ERR, 8'd0, 20'd0, 1'b1);
      end else begin
        run_len = sum[19:0];
        w = w << 1;
        if (w > WEIGHT_CAP) begin
          w = WEIGHT_CAP;
        end
        run_wt = w[20:0];
      end
    end else if ({1'b0, s} > eob) begin
      // Above end of block: the pending run is dropped unflushed.
      run_len = '0;
      run_wt = '0;
      push_want(KIND_ERR, 8'd0, 20'd0, 1'b1);
    end else begin
      if (run_len != '0) begin
        push_want(KIND_RUN, list_m[0], run_len, 1'b0);
      end
      run_len = '0;
      run_wt = '0;
      if ({1'b0, s} == eob) begin
        push_want(KIND_END, 8'd0, 20'd0, 1'b1);
      end else begin
        // Move entry s-1 to the front and emit it once.
        idx = int'(s) - 1;
        v = list_m[idx];
        for (int z = idx; z > 0; z--) begin
          list_m[z] = list_m[z - 1];
        end
        list_m[0] = v;
        push_want(KIND_RUN, v, 20'd1, 1'b1);
      end
    end
  endtask

  // Compare one accepted result with the oldest expectation.
  task automatic check_result();
    res_t w;
    if (want_q.size() == 0) begin
      report_mismatch($sformatf("result with none expected: kind %0d byte %0d rep %0d last %0d",
                                kind, out_byte, repeat_res, is_last));
    end else begin
      w = want_q.pop_front();
      if (kind !== w.kind) begin
        report_mismatch($sformatf("kind got %0d want %0d", kind, w.kind));
      end
      if (out_byte !== w.out_byte) begin
        report_mismatch($sformatf("out_byte got %0d want %0d", out_byte, w.out_byte));
      end
      if (repeat_res !== w.repeat_res) begin
        report_mismatch($sformatf("repeat_res got %0d want %0d", repeat_res, w.repeat_res));
      end
      if (is_last !== w.is_last) begin
        report_mismatch($sformatf("is_last got %0d want %0d", is_last, w.is_last));
      end
      case (w.kind)
        KIND_RUN: seen_run++;
        KIND_END: seen_end++;
        default: seen_err++;
      endcase
    end
  endtask

  // Driver: presents queued items, with random gaps between them.
  always @(posedge clk) begin
    sym_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stim_q.size() != 0) begin
        it = stim_q.pop_front();
        func <= it.func;
        symbol <= it.sym;
        load_index <= it.idx;
        load_value <= it.val;
        in_valid <= 1'b1;
        gap_left <= quiet_in ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        items_in++;
        predict_decode(func, symbol, load_index, load_value);
      end
      if (out_valid && out_ready) begin
        check_result();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_mtf_zero_run_symbol_decoder: done, errors");
      $finish;
    end
  end

  function automatic void add_item(input logic f, input logic [8:0] s,
                                   input logic [7:0] li, input logic [7:0] lv);
    sym_item_t it;
    it.func = f;
    it.sym = s;
    it.idx = li;
    it.val = lv;
    stim_q.insert(stim_q.size(), it);
    queued_items++;
  endfunction

  // Decode item with random filler in the unused load fields.
  function automatic void add_sym(input logic [8:0] s);
    add_item(FUNC_DECODE, s, 8'($urandom), 8'($urandom));
  endfunction

  // Symbol that ends a run: mostly a list index, sometimes end of block.
  function automatic logic [8:0] pick_term(input int n);
    if (n == 1 || $urandom_range(0, 99) < 12) begin
      return 9'(n + 1);
    end
    if ($urandom_range(0, 1) == 0) begin
      return 9'($urandom_range(2, (n + 1 < 6) ? n + 1 : 6));
    end
    return 9'($urandom_range(2, n + 1));
  endfunction

  // Random traffic: mostly well-formed runs and symbols, some loads and noise.
  task automatic gen_random(input int count);
    int n;
    int r;
    int len;
    int mode;
    int lo;
    int stop_at;
    n = (in_use_m == 0) ? 1 : ((in_use_m > 9'd256) ? 256 : int'(in_use_m));
    stop_at = queued_items + count;
    while (queued_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        add_item(FUNC_LOAD, 9'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 10) begin
        // Long run to reach weight saturation and run overflow.
        len = $urandom_range(17, 22);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
          add_sym((mode == 0) ? SYM_RUNA : (mode == 1) ? SYM_RUNB :
                  9'($urandom_range(0, 1)));
        end
        add_sym(pick_term(n));
      end else if (r < 15) begin
        // Symbol above end of block, sometimes after a run.
        if ($urandom_range(0, 1) == 0) begin
          add_sym(9'($urandom_range(0, 1)));
        end
        lo = n + 2;
        if (lo <= 257 && $urandom_range(0, 3) != 0) begin
          add_sym(9'($urandom_range(lo, 257)));
        end else begin
          add_sym(9'($urandom_range(258, 511)));
        end
      end else begin
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) begin
          add_sym(9'($urandom_range(0, 1)));
        end
        add_sym(pick_term(n));
      end
    end
  endtask

  // Wait until every item is taken and every result is back, then settle.
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (stim_q.size() != 0 || in_valid || want_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_in_use(input logic [8:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    in_use_m = v;
    phases_run++;
  endtask

  // Main sequence.
  initial begin
    logic [8:0] settings[10];
    settings = '{9'd1, 9'd2, 9'd0, 9'd300, 9'd511, 9'd256, 9'd37, 9'd255, 9'd128,
                 9'($urandom_range(3, 254))};
    for (int i = 0; i < 256; i++) begin
      list_m[i] = 8'(i);
    end
    run_len = '0;
    run_wt = '0;
    in_use_m = 9'd256;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset setting of 256 symbols in use.
    add_item(FUNC_LOAD, 9'd0, 8'd0, 8'd255);
    add_item(FUNC_LOAD, 9'd511, 8'd255, 8'd0);
    add_sym(9'd2);
    add_sym(9'd256);
    add_sym(SYM_RUNA);
    add_sym(SYM_RUNB);
    add_sym(SYM_RUNA);
    add_sym(9'd3);
    add_sym(SYM_RUNB);
    add_sym(9'd257);
    add_sym(9'd257);
    add_sym(SYM_RUNA);
    add_item(FUNC_LOAD, 9'd2, 8'd7, 8'h5A);
    add_sym(9'd2);
    add_sym(SYM_RUNB);
    wait_idle();

    // Directed part with a shorter alphabet: symbols above end of block.
    write_in_use(9'd200);
    add_sym(9'd202);
    add_sym(SYM_RUNA);
    add_sym(9'd201);
    add_sym(9'd257);
    add_sym(9'd200);
    add_sym(SYM_RUNA);
    add_sym(9'd256);
    wait_idle();

    // Random phases, one per setting of the symbol count.
    for (int p = 0; p < 10; p++) begin
      quiet_in = (p == 5 || p == 7);
      quiet_out = (p == 5);
      write_in_use(settings[p]);
      if (p == 2) begin
        // Sender holds off until all results of the first half are back.
        gen_random(PHASE_ITEMS / 2);
        wait_idle();
        gen_random(PHASE_ITEMS / 2);
      end else begin
        gen_random(PHASE_ITEMS);
      end
      wait_idle();
    end

    $display("Covered %0d accepted items across %0d symbol-count settings.",
             items_in, phases_run + 1);
    $display("Checked %0d byte runs, %0d end-of-block and %0d error results.",
             seen_run, seen_end, seen_err);
    if (err_count == 0) begin
      $display("tb_mtf_zero_run_symbol_decoder: done, clean");
    end else begin
      $display("tb_mtf_zero_run_symbol_decoder: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mzr_pkg.sv
rtl/core/mzr_ctrl.sv
rtl/core/mzr_dp.sv
rtl/core/mzr_outq.sv
rtl/core/mtf_zero_run_symbol_decoder.sv
sim/tb_mtf_zero_run_symbol_decoder.sv
